### rtl/sfcr_pkg.sv
package sfcr_pkg;

  // Byte that opens a sensor frame while the receiver is hunting.
  localparam logic [7:0] START_BYTE = 8'hFF;

  // Frame positions of the integer and fraction bytes of the reading.
  localparam int INT_POS  = 3;
  localparam int FRAC_POS = 4;

  // Scale applied to the reading and the divisor of the result split.
  localparam logic [12:0] SCALE    = 13'd18;
  localparam logic [12:0] HUNDRED  = 13'd100;

  // floor(18*b/100) equals (b*DIV_MUL) >> DIV_SHIFT for every 8-bit b.
  localparam logic [14:0] DIV_MUL   = 15'd23598;
  localparam int          DIV_SHIFT = 17;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_START_FLAG = 2'd0,
    REG_MODULE_ID  = 2'd1,
    REG_MODE       = 2'd2
  } cfg_reg_t;

  // Position of a beat within the seven-byte result frame.
  typedef enum logic [2:0] {
    OB_START = 3'd0,
    OB_ID    = 3'd1,
    OB_MODE  = 3'd2,
    OB_INT   = 3'd3,
    OB_FRAC  = 3'd4,
    OB_ZERO  = 3'd5,
    OB_SUM   = 3'd6
  } out_pos_t;

endpackage

### rtl/sensor_frame_check_and_reformat.sv
// Sensor frame checker and reformatter.
//
// The input channel (in_valid, in_stall, rx_byte) carries one received link
// byte per beat. While hunting, a 0xFF byte opens a frame; the block then
// collects FRAME_BYTES-1 more bytes, checks the closing two's complement
// checksum and silently drops a frame that fails it. A good frame produces
// seven beats on the output channel (out_valid, out_stall, tx_byte, last):
// start flag, module id, mode, reading/100, reading%100, zero and checksum,
// with last high on the checksum beat.
// An input byte is taken every cycle, one per beat, while in_stall is low. The
// first result beat is valid in the cycle after the closing frame byte is
// accepted, and the seven beats then drain at one per cycle while out_stall
// is low. Only the closing byte of the next frame waits (in_stall high) while
// a result frame is still in the output register, so a stalled receiver holds
// up the link only at a frame boundary. Division by 100 is split across the
// fraction and closing bytes, so each needs only constant multiplies, shifts
// and adds or subtracts. Synchronous reset clears the configuration registers
// to zero, returns the receiver to hunting and empties the output register.
module sensor_frame_check_and_reformat #(
  parameter int FRAME_BYTES = 9
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] INT_IDX  = IDX_W'(sfcr_pkg::INT_POS);
  localparam logic [IDX_W-1:0] FRAC_IDX = IDX_W'(sfcr_pkg::FRAC_POS);

  // Configuration registers.
  logic [7:0] start_flag;
  logic [7:0] module_id;
  logic [7:0] mode;

  // Frame receiver state.
  logic             in_frame;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       running_sum;
  logic [7:0]       integer_part;
  logic [12:0]      frac_scaled;
  logic [5:0]       frac_quot;

  // Result register.
  logic                 out_valid_r;
  sfcr_pkg::out_pos_t   out_cnt;
  logic [7:0]           res_int;
  logic [6:0]           res_frac;
  logic [7:0]           res_sum;

  logic        in_acc;
  logic        out_acc;
  logic        at_last;
  logic        sum_ok;
  logic [22:0] quot_prod;
  logic [12:0] rx_scaled;
  logic [7:0]  int_byte;
  logic [12:0] rem_full;
  logic [7:0]  csum_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_flag <= '0;
      module_id  <= '0;
      mode       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfcr_pkg::REG_START_FLAG: start_flag <= cfg_data;
        sfcr_pkg::REG_MODULE_ID:  module_id  <= cfg_data;
        sfcr_pkg::REG_MODE:       mode       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The closing byte of a frame may not enter while a result frame is still
  // held, since it would overwrite the result register.
  assign at_last  = in_frame && (byte_index >= LAST_IDX);
  assign in_stall = out_valid_r && at_last;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // The reading is 1800*b3 + 18*b4. The first term divides by 100 exactly,
  // so the quotient is 18*b3 + floor(18*b4/100) and the remainder comes from
  // 18*b4 alone. The fraction half is worked out when byte 4 arrives.
  assign rx_scaled = {5'b0, rx_byte} * sfcr_pkg::SCALE;
  assign quot_prod = {15'b0, rx_byte} * {8'b0, sfcr_pkg::DIV_MUL};

  assign sum_ok    = (rx_byte + running_sum) == 8'h00;
  assign int_byte  = 8'(integer_part * 8'd18) + {2'b0, frac_quot};
  assign rem_full  = frac_scaled - 13'({7'b0, frac_quot} * sfcr_pkg::HUNDRED);
  assign csum_byte = start_flag + module_id + mode + int_byte + {1'b0, rem_full[6:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_index  <= '0;
      running_sum <= '0;
    end else if (in_acc) begin
      if (!in_frame) begin
        if (rx_byte == sfcr_pkg::START_BYTE) begin
          in_frame    <= 1'b1;
          byte_index  <= IDX_W'(1);
          running_sum <= '0;
        end
      end else if (at_last) begin
        in_frame   <= 1'b0;
        byte_index <= '0;
      end else begin
        running_sum <= running_sum + rx_byte;
        byte_index  <= byte_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_frame && !at_last) begin
      if (byte_index == INT_IDX) begin
        integer_part <= rx_byte;
      end
      if (byte_index == FRAC_IDX) begin
        frac_scaled <= rx_scaled;
        frac_quot   <= quot_prod[22:sfcr_pkg::DIV_SHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
      out_cnt     <= sfcr_pkg::OB_START;
    end else if (in_acc && at_last && sum_ok) begin
      out_valid_r <= 1'b1;
      out_cnt     <= sfcr_pkg::OB_START;
    end else if (out_acc) begin
      if (out_cnt == sfcr_pkg::OB_SUM) begin
        out_valid_r <= 1'b0;
        out_cnt     <= sfcr_pkg::OB_START;
      end else begin
        out_cnt <= sfcr_pkg::out_pos_t'(out_cnt + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && at_last && sum_ok) begin
      res_int  <= int_byte;
      res_frac <= rem_full[6:0];
      res_sum  <= csum_byte;
    end
  end

  always_comb begin
    unique case (out_cnt)
      sfcr_pkg::OB_START: tx_byte = start_flag;
      sfcr_pkg::OB_ID:    tx_byte = module_id;
      sfcr_pkg::OB_MODE:  tx_byte = mode;
      sfcr_pkg::OB_INT:   tx_byte = res_int;
      sfcr_pkg::OB_FRAC:  tx_byte = {1'b0, res_frac};
      sfcr_pkg::OB_ZERO:  tx_byte = 8'h00;
      sfcr_pkg::OB_SUM:   tx_byte = res_sum;
      default:            tx_byte = 8'h00;
    endcase
  end

  assign last      = (out_cnt == sfcr_pkg::OB_SUM);
  assign out_valid = out_valid_r;

  // Input is held back only while a result frame occupies the output.
  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result frame pending");

  // A result frame always starts at its first beat.
  a_frame_starts_at_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_cnt == sfcr_pkg::OB_START))
    else $error("result frame did not start at the start flag beat");

  // Delivering the checksum beat ends the result frame.
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("output still valid after the last beat was taken");

  // The byte counter is parked at zero while hunting.
  a_hunt_index_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (byte_index == '0))
    else $error("byte index not cleared while hunting");

endmodule
